/* rtl/smi_pkg.sv */
// ----------------------------------------------------------------------------
// smi_pkg
// Shared types and constants for the byte string multiset intersection block.
// ----------------------------------------------------------------------------
package smi_pkg;

  localparam int unsigned MaxLen   = 4096;
  localparam int unsigned CntW     = $clog2(MaxLen + 1);
  localparam int unsigned ChW      = 8;
  localparam int unsigned NumChars = 1 << ChW;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [ChW-1:0]  ch_t;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_STREAM = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    ch_t  ch;
    logic last;
  } in_item_t;

  typedef struct packed {
    ch_t  out_char;
    logic keep;
    logic out_last;
  } out_item_t;

  // Update request to the valid bit table
  typedef struct packed {
    logic set;
    logic clr;
    ch_t  idx;
  } vt_req_t;

endpackage

/* rtl/smi_count_ram.sv */
// ----------------------------------------------------------------------------
// smi_count_ram
// Count memory, one entry per byte value; one write and one registered read.
// ----------------------------------------------------------------------------
module smi_count_ram (
  input  logic          clk_i,
  input  logic          we_i,
  input  smi_pkg::ch_t  waddr_i,
  input  smi_pkg::cnt_t wdata_i,
  input  logic          re_i,
  input  smi_pkg::ch_t  raddr_i,
  output smi_pkg::cnt_t rdata_o
);

  smi_pkg::cnt_t mem [smi_pkg::NumChars];
  smi_pkg::cnt_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read-before-write: a same-address write in the same cycle is not seen
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/smi_valid_table.sv */
// ----------------------------------------------------------------------------
// smi_valid_table
// One valid bit per count entry; set on write, flash cleared at job end.
// ----------------------------------------------------------------------------
module smi_valid_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  smi_pkg::vt_req_t req_i,
  input  smi_pkg::ch_t     rd_idx_i,
  output logic             rd_valid_o
);

  logic [smi_pkg::NumChars-1:0] valid_q;
  logic [smi_pkg::NumChars-1:0] valid_d;

  // Clear wins over a set in the same cycle
  always_comb begin
    valid_d = valid_q;
    if (req_i.set) begin
      valid_d[req_i.idx] = 1'b1;
    end
    if (req_i.clr) begin
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rd_valid_o = valid_q[rd_idx_i];

endmodule

/* rtl/string_multiset_intersection.sv */
// ----------------------------------------------------------------------------
// string_multiset_intersection
// Counts first-string bytes into a table, then marks second-string bytes.
// ----------------------------------------------------------------------------
// Stage one, then the output register, hold a streamed item and its result.
// Throughput: one item per cycle while the output is not stalled; the count
// memory read-modify-write is forwarded for back-to-back same-byte items.
// Reset: clears pipeline control and all valid bits, so every count reads as
// zero; the count memory itself is not cleared and needs no clearing pass.
module string_multiset_intersection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  smi_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output smi_pkg::out_item_t out_o
);

  logic               in_fire;
  logic               s1_valid_q, s1_valid_d;
  smi_pkg::in_item_t  s1_item_q;
  logic               s1_fire;
  logic               s1_stream;
  logic               fwd_q, fwd_d;
  smi_pkg::cnt_t      fwd_val_q;
  smi_pkg::cnt_t      rd_data;
  logic               rd_valid;
  smi_pkg::cnt_t      cnt_cur;
  smi_pkg::cnt_t      cnt_new;
  logic               keep;
  logic               wr_en;
  logic               job_end;
  smi_pkg::vt_req_t   vt_req;
  logic               out_valid_q, out_valid_d;
  smi_pkg::out_item_t out_q;

  assign s1_stream = (s1_item_q.cmd == smi_pkg::CMD_STREAM);
  assign s1_fire   = s1_valid_q && (!s1_stream || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire   = in_valid_i && in_ready_o;

  smi_count_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_item_q.ch),
    .wdata_i (cnt_new),
    .re_i    (in_fire),
    .raddr_i (in_i.ch),
    .rdata_o (rd_data)
  );

  smi_valid_table u_vt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (vt_req),
    .rd_idx_i   (s1_item_q.ch),
    .rd_valid_o (rd_valid)
  );

  // Current count: forwarded write, else memory gated by its valid bit
  always_comb begin
    if (fwd_q) begin
      cnt_cur = fwd_val_q;
    end else if (rd_valid) begin
      cnt_cur = rd_data;
    end else begin
      cnt_cur = '0;
    end
  end

  always_comb begin
    keep    = 1'b0;
    cnt_new = cnt_cur;
    unique case (s1_item_q.cmd)
      smi_pkg::CMD_LOAD: begin
        if (cnt_cur < smi_pkg::cnt_t'(smi_pkg::MaxLen)) begin
          cnt_new = cnt_cur + smi_pkg::cnt_t'(1);
        end else begin
          cnt_new = smi_pkg::cnt_t'(smi_pkg::MaxLen);
        end
      end
      smi_pkg::CMD_STREAM: begin
        keep    = (cnt_cur != '0);
        cnt_new = cnt_cur - smi_pkg::cnt_t'(1);
      end
      default: begin
        cnt_new = cnt_cur;
      end
    endcase
  end

  assign wr_en   = s1_fire && (!s1_stream || keep);
  assign job_end = s1_fire && s1_stream && s1_item_q.last;

  assign vt_req.set = wr_en;
  assign vt_req.clr = job_end;
  assign vt_req.idx = s1_item_q.ch;

  // The memory read misses a write landing on the same edge; a job end
  // clears everything, so nothing is forwarded across it
  assign fwd_d = wr_en && !job_end && (s1_item_q.ch == in_i.ch);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_stream) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        fwd_q <= fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_i;
      fwd_val_q <= cnt_new;
    end
    if (s1_fire && s1_stream) begin
      out_q.out_char <= s1_item_q.ch;
      out_q.keep     <= keep;
      out_q.out_last <= s1_item_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
